### design/lcab_pkg.sv
// ----------------------------------------------------------------------------
// lcab_pkg
// Shared constants, command codes and controller/datapath interface types
// for the binary-lifting lowest-common-ancestor engine.
// ----------------------------------------------------------------------------
package lcab_pkg;

   localparam int NODES_DEF   = 1024;
   localparam int LEVELS_DEF  = 10;

   localparam int FIELD_W     = 10;
   localparam int LEVEL_W     = 11;
   localparam int J_W         = 5;
   localparam int OP_W        = 4;
   localparam int RECIP_SHIFT = 20;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 11'h7FF;

   localparam logic KIND_ATTACH = 1'b0;

   localparam logic [OP_W-1:0] OP_NONE      = 4'd0;
   localparam logic [OP_W-1:0] OP_LOAD      = 4'd1;
   localparam logic [OP_W-1:0] OP_RED_Q     = 4'd2;
   localparam logic [OP_W-1:0] OP_RED_R     = 4'd3;
   localparam logic [OP_W-1:0] OP_ATTACH    = 4'd4;
   localparam logic [OP_W-1:0] OP_QUERY     = 4'd5;
   localparam logic [OP_W-1:0] OP_A_LVL     = 4'd6;
   localparam logic [OP_W-1:0] OP_FILL      = 4'd7;
   localparam logic [OP_W-1:0] OP_Q_LVL     = 4'd8;
   localparam logic [OP_W-1:0] OP_LIFT      = 4'd9;
   localparam logic [OP_W-1:0] OP_LIFT_END  = 4'd10;
   localparam logic [OP_W-1:0] OP_HIT       = 4'd11;
   localparam logic [OP_W-1:0] OP_CLIMB     = 4'd12;
   localparam logic [OP_W-1:0] OP_CLIMB_END = 4'd13;
   localparam logic [OP_W-1:0] OP_FINAL     = 4'd14;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic [J_W-1:0]  idx;
      logic            pend;
   } lcab_cmd_type;

   typedef struct packed {
      logic kind;
      logic first_zero;
      logic nodes_eq;
      logic lift_bit;
   } lcab_sts_type;

endpackage

### design/lcab_ram.sv
// ----------------------------------------------------------------------------
// lcab_ram
// Generic RAM: one write port, two read ports, registered write-first reads
// that hold their data while the read enable is low.
// ----------------------------------------------------------------------------
module lcab_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= (wr_en && wr_addr == rd_addr_a) ? wr_data : mem[rd_addr_a];
         rd_b_ff <= (wr_en && wr_addr == rd_addr_b) ? wr_data : mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

### design/lcab_ctrl.sv
// ----------------------------------------------------------------------------
// lcab_ctrl
// Sequencer for attach and query requests: issues one datapath command per
// cycle and steps the level index of the fill, lift and climb loops.
// ----------------------------------------------------------------------------
module lcab_ctrl #(
   parameter int LEVELS = lcab_pkg::LEVELS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  lcab_pkg::lcab_sts_type sts,
   output lcab_pkg::lcab_cmd_type cmd
);
   import lcab_pkg::*;

   localparam logic [J_W-1:0] J_LAST = J_W'(LEVELS - 1);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_RED_Q     = 4'd1;
   localparam logic [3:0] ST_RED_R     = 4'd2;
   localparam logic [3:0] ST_DISPATCH  = 4'd3;
   localparam logic [3:0] ST_A_LVL     = 4'd4;
   localparam logic [3:0] ST_FILL      = 4'd5;
   localparam logic [3:0] ST_Q_LVL     = 4'd6;
   localparam logic [3:0] ST_LIFT      = 4'd7;
   localparam logic [3:0] ST_LIFT_END  = 4'd8;
   localparam logic [3:0] ST_CMP       = 4'd9;
   localparam logic [3:0] ST_CLIMB     = 4'd10;
   localparam logic [3:0] ST_CLIMB_END = 4'd11;
   localparam logic [3:0] ST_FINAL     = 4'd12;

   logic [3:0]     state_ff, state_in;
   logic [J_W-1:0] j_ff, j_in;
   logic           pend_ff, pend_in;
   logic [OP_W-1:0] op;

   always_comb begin
      state_in = state_ff;
      j_in     = j_ff;
      pend_in  = pend_ff;
      op       = OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op       = OP_LOAD;
               state_in = ST_RED_Q;
            end
         end
         ST_RED_Q: begin
            op       = OP_RED_Q;
            state_in = ST_RED_R;
         end
         ST_RED_R: begin
            op       = OP_RED_R;
            state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            if (sts.kind == KIND_ATTACH) begin
               if (sts.first_zero) begin
                  state_in = ST_IDLE;
               end else begin
                  op       = OP_ATTACH;
                  state_in = ST_A_LVL;
               end
            end else if (sts.nodes_eq) begin
               op       = OP_HIT;
               state_in = ST_IDLE;
            end else begin
               op       = OP_QUERY;
               state_in = ST_Q_LVL;
            end
         end
         ST_A_LVL: begin
            op = OP_A_LVL;
            if (LEVELS == 1) begin
               state_in = ST_IDLE;
            end else begin
               j_in     = J_W'(1);
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            op = OP_FILL;
            if (j_ff == J_LAST) begin
               state_in = ST_IDLE;
            end else begin
               j_in = j_ff + J_W'(1);
            end
         end
         ST_Q_LVL: begin
            op       = OP_Q_LVL;
            j_in     = J_LAST;
            pend_in  = 1'b0;
            state_in = ST_LIFT;
         end
         ST_LIFT: begin
            op      = OP_LIFT;
            pend_in = sts.lift_bit;
            if (j_ff == '0) begin
               state_in = ST_LIFT_END;
            end else begin
               j_in = j_ff - J_W'(1);
            end
         end
         ST_LIFT_END: begin
            op       = OP_LIFT_END;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (sts.nodes_eq) begin
               op       = OP_HIT;
               state_in = ST_IDLE;
            end else begin
               j_in     = J_LAST;
               pend_in  = 1'b0;
               state_in = ST_CLIMB;
            end
         end
         ST_CLIMB: begin
            op      = OP_CLIMB;
            pend_in = 1'b1;
            if (j_ff == '0) begin
               state_in = ST_CLIMB_END;
            end else begin
               j_in = j_ff - J_W'(1);
            end
         end
         ST_CLIMB_END: begin
            op       = OP_CLIMB_END;
            state_in = ST_FINAL;
         end
         ST_FINAL: begin
            op       = OP_FINAL;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         j_ff     <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         j_ff     <= j_in;
         pend_ff  <= pend_in;
      end
   end

   assign busy     = (state_ff != ST_IDLE);
   assign cmd.op   = op;
   assign cmd.idx  = j_ff;
   assign cmd.pend = pend_ff;

   a_j_range: assert property (@(posedge clock) disable iff (reset)
      j_ff <= J_LAST)
      else $error("level index beyond table");

   a_fill_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL) |-> (j_ff != '0))
      else $error("fill pass at level zero");

endmodule

### design/lcab_dpath.sv
// ----------------------------------------------------------------------------
// lcab_dpath
// Datapath: node reduction, level and ancestor tables, lift and climb
// registers, and the result register.
// ----------------------------------------------------------------------------
module lcab_dpath #(
   parameter int NODES  = lcab_pkg::NODES_DEF,
   parameter int LEVELS = lcab_pkg::LEVELS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_kind,
   input  logic [lcab_pkg::FIELD_W-1:0] req_first_node,
   input  logic [lcab_pkg::FIELD_W-1:0] req_second_node,
   input  lcab_pkg::lcab_cmd_type       cmd,
   output lcab_pkg::lcab_sts_type       sts,
   output logic                         rsp_valid,
   output logic [lcab_pkg::FIELD_W-1:0] rsp_ancestor
);
   import lcab_pkg::*;

   localparam int NW        = $clog2(NODES);
   localparam int LW        = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int AW        = NW + LW;
   localparam int ANC_DEPTH = (1 << NW) << LW;
   localparam int RECIP     = (1 << RECIP_SHIFT) / NODES;
   localparam int PW        = FIELD_W + RECIP_SHIFT;
   localparam int RW        = FIELD_W + $clog2(NODES + 1) + 1;

   function automatic logic [NW-1:0] rem_fix(logic [FIELD_W-1:0] raw,
                                             logic [FIELD_W-1:0] q);
      logic [RW-1:0] r;
      r = RW'(raw) - RW'(q) * RW'(NODES);
      if (r >= RW'(NODES)) begin
         r = r - RW'(NODES);
      end
      return NW'(r);
   endfunction

   function automatic logic [AW-1:0] anc_addr(logic [NW-1:0] n, logic [LW-1:0] j);
      return {n, j};
   endfunction

   logic               kind_ff, kind_in;
   logic [FIELD_W-1:0] raw_a_ff, raw_a_in, raw_b_ff, raw_b_in;
   logic [FIELD_W-1:0] qa_ff, qa_in, qb_ff, qb_in;
   logic [NW-1:0]      u_ff, u_in, v_ff, v_in;
   logic [LEVELS-1:0]  diff_ff, diff_in;
   logic               za_ff, za_in, zb_ff, zb_in;
   logic               lza_ff, lza_in, lzb_ff, lzb_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0] rsp_anc_ff, rsp_anc_in;

   logic [PW-1:0]      prod_a, prod_b;
   logic [LW-1:0]      jx;

   logic               anc_we, anc_re;
   logic [AW-1:0]      anc_wa, anc_ra, anc_rb;
   logic [NW-1:0]      anc_wd, anc_rd_a, anc_rd_b, anc_a, anc_b;
   logic               lvl_we, lvl_re;
   logic [NW-1:0]      lvl_wa, lvl_ra, lvl_rb;
   logic [LEVEL_W-1:0] lvl_wd, lvl_rd_a, lvl_rd_b, lvl_a, lvl_b;

   logic               differ;
   logic [NW-1:0]      cur_u, cur_v;

   lcab_ram #(.WIDTH(NW), .DEPTH(ANC_DEPTH)) u_anc_ram (
      .clock     (clock),
      .wr_en     (anc_we),
      .wr_addr   (anc_wa),
      .wr_data   (anc_wd),
      .rd_en     (anc_re),
      .rd_addr_a (anc_ra),
      .rd_addr_b (anc_rb),
      .rd_data_a (anc_rd_a),
      .rd_data_b (anc_rd_b)
   );

   lcab_ram #(.WIDTH(LEVEL_W), .DEPTH(NODES)) u_lvl_ram (
      .clock     (clock),
      .wr_en     (lvl_we),
      .wr_addr   (lvl_wa),
      .wr_data   (lvl_wd),
      .rd_en     (lvl_re),
      .rd_addr_a (lvl_ra),
      .rd_addr_b (lvl_rb),
      .rd_data_a (lvl_rd_a),
      .rd_data_b (lvl_rd_b)
   );

   // node 0 is never written; its entries read as zero
   assign anc_a = za_ff  ? '0 : anc_rd_a;
   assign anc_b = zb_ff  ? '0 : anc_rd_b;
   assign lvl_a = lza_ff ? '0 : lvl_rd_a;
   assign lvl_b = lzb_ff ? '0 : lvl_rd_b;

   assign jx     = cmd.idx[LW-1:0];
   assign prod_a = PW'(raw_a_ff) * PW'(RECIP);
   assign prod_b = PW'(raw_b_ff) * PW'(RECIP);

   assign differ = cmd.pend && (anc_a != anc_b);
   assign cur_u  = (cmd.op == OP_CLIMB || cmd.op == OP_CLIMB_END) ?
                   (differ ? anc_a : u_ff) : (cmd.pend ? anc_a : u_ff);
   assign cur_v  = differ ? anc_b : v_ff;

   always_comb begin
      kind_in      = kind_ff;
      raw_a_in     = raw_a_ff;
      raw_b_in     = raw_b_ff;
      qa_in        = qa_ff;
      qb_in        = qb_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      diff_in      = diff_ff;
      za_in        = za_ff;
      zb_in        = zb_ff;
      lza_in       = lza_ff;
      lzb_in       = lzb_ff;
      rsp_valid_in = 1'b0;
      rsp_anc_in   = rsp_anc_ff;
      anc_we       = 1'b0;
      anc_wa       = anc_addr(u_ff, jx);
      anc_wd       = anc_a;
      anc_re       = 1'b0;
      anc_ra       = anc_addr(cur_u, jx);
      anc_rb       = anc_addr(cur_v, jx);
      lvl_we       = 1'b0;
      lvl_wa       = u_ff;
      lvl_wd       = (lvl_a == LEVEL_MAX) ? LEVEL_MAX : lvl_a + LEVEL_W'(1);
      lvl_re       = 1'b0;
      lvl_ra       = u_ff;
      lvl_rb       = v_ff;
      unique case (cmd.op)
         OP_LOAD: begin
            kind_in  = req_kind;
            raw_a_in = req_first_node;
            raw_b_in = req_second_node;
         end
         OP_RED_Q: begin
            qa_in = prod_a[PW-1:RECIP_SHIFT];
            qb_in = prod_b[PW-1:RECIP_SHIFT];
         end
         OP_RED_R: begin
            u_in = rem_fix(raw_a_ff, qa_ff);
            v_in = rem_fix(raw_b_ff, qb_ff);
         end
         OP_ATTACH: begin
            anc_we = 1'b1;
            anc_wa = anc_addr(u_ff, '0);
            anc_wd = v_ff;
            anc_re = 1'b1;
            anc_ra = anc_addr(v_ff, '0);
            za_in  = (v_ff == '0);
            lvl_re = 1'b1;
            lvl_ra = v_ff;
            lza_in = (v_ff == '0);
         end
         OP_QUERY: begin
            lvl_re = 1'b1;
            lza_in = (u_ff == '0);
            lzb_in = (v_ff == '0);
         end
         OP_A_LVL: begin
            lvl_we = 1'b1;
         end
         OP_FILL: begin
            anc_we = 1'b1;
            anc_re = 1'b1;
            anc_ra = anc_addr(anc_a, jx);
            za_in  = (anc_a == '0);
         end
         OP_Q_LVL: begin
            if (lvl_a < lvl_b) begin
               u_in    = v_ff;
               v_in    = u_ff;
               diff_in = LEVELS'(lvl_b - lvl_a);
            end else begin
               diff_in = LEVELS'(lvl_a - lvl_b);
            end
         end
         OP_LIFT: begin
            u_in = cur_u;
            if (diff_ff[jx]) begin
               anc_re = 1'b1;
               za_in  = (cur_u == '0);
            end
         end
         OP_LIFT_END: begin
            u_in = cur_u;
         end
         OP_HIT: begin
            rsp_valid_in = 1'b1;
            rsp_anc_in   = FIELD_W'(u_ff);
         end
         OP_CLIMB: begin
            u_in   = cur_u;
            v_in   = cur_v;
            anc_re = 1'b1;
            za_in  = (cur_u == '0);
            zb_in  = (cur_v == '0);
         end
         OP_CLIMB_END: begin
            u_in   = cur_u;
            v_in   = cur_v;
            anc_re = 1'b1;
            anc_ra = anc_addr(cur_u, '0);
            za_in  = (cur_u == '0);
         end
         OP_FINAL: begin
            rsp_valid_in = 1'b1;
            rsp_anc_in   = FIELD_W'(anc_a);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      raw_a_ff   <= raw_a_in;
      raw_b_ff   <= raw_b_in;
      qa_ff      <= qa_in;
      qb_ff      <= qb_in;
      u_ff       <= u_in;
      v_ff       <= v_in;
      diff_ff    <= diff_in;
      za_ff      <= za_in;
      zb_ff      <= zb_in;
      lza_ff     <= lza_in;
      lzb_ff     <= lzb_in;
      rsp_anc_ff <= rsp_anc_in;
   end

   assign sts.kind       = kind_ff;
   assign sts.first_zero = (u_ff == '0);
   assign sts.nodes_eq   = (u_ff == v_ff);
   assign sts.lift_bit   = diff_ff[jx];

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_ancestor = rsp_anc_ff;

endmodule

### design/lca_binary_lifting.sv
// ----------------------------------------------------------------------------
// lca_binary_lifting
// Lowest-common-ancestor engine over a rooted tree kept as a binary-lifting
// ancestor table.
// ----------------------------------------------------------------------------
// A request is taken at a clock edge with start high and busy low. Kind 0
// attaches req_first_node under req_second_node (0 for a root); kind 1 asks
// for the lowest common ancestor of the two nodes. Node numbers are reduced
// modulo NODES.
// An attach gives no response and ends sooner for node 0. A query ends
// sooner when both nodes are equal or when one is an ancestor of the other;
// the answer is on rsp_ancestor with rsp_valid high for one cycle right after,
// the cycle in which busy has dropped. The receiver cannot stall.
// The busy time is set by the chain of dependent reads of the ancestor RAM:
// one registered read per level for the fill and lift passes, and one pair
// per level for the climb pass.
// Reset is synchronous and returns the sequencer to idle. No clearing pass:
// node 0 reads as zero by address decode, and other entries are valid once
// attached.
// ----------------------------------------------------------------------------
module lca_binary_lifting #(
   parameter int NODES  = lcab_pkg::NODES_DEF,
   parameter int LEVELS = lcab_pkg::LEVELS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_kind,
   input  logic [lcab_pkg::FIELD_W-1:0] req_first_node,
   input  logic [lcab_pkg::FIELD_W-1:0] req_second_node,
   output logic                         rsp_valid,
   output logic [lcab_pkg::FIELD_W-1:0] rsp_ancestor
);
   import lcab_pkg::*;

   lcab_cmd_type cmd;
   lcab_sts_type sts;

   lcab_ctrl #(.LEVELS(LEVELS)) u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   lcab_dpath #(.NODES(NODES), .LEVELS(LEVELS)) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_kind        (req_kind),
      .req_first_node  (req_first_node),
      .req_second_node (req_second_node),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_valid       (rsp_valid),
      .rsp_ancestor    (rsp_ancestor)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request taken but block not busy");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while still busy");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back responses");

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the binary-lifting lowest-common-ancestor engine. Attach and query
// requests are driven through the start/busy handshake. A scoreboard keeps
// its own level and ancestor tables, predicts the answer of every accepted
// query, and compares each response strobe with the oldest prediction. A
// directed pass covers roots, ignored sentinel attaches, self queries,
// reattached and self-parented nodes, and deep reattach chains. Random trees
// follow under several sender idle rates.
// ----------------------------------------------------------------------------
module testbench;
   import lcab_pkg::*;

   localparam int NODE_COUNT = NODES_DEF;
   localparam int LEVEL_COUNT = LEVELS_DEF;
   localparam logic KIND_QUERY = 1'b1;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int SETTLE_CYCLES = 2 * LEVELS_DEF + 12;

   class ancestor_tracker;
      logic [LEVEL_W-1:0] depth_of [NODE_COUNT];
      logic [FIELD_W-1:0] jump [NODE_COUNT * LEVEL_COUNT];
      logic [FIELD_W-1:0] pending_ancestors [$];
      int failures;

      function new();
         foreach (depth_of[i]) depth_of[i] = '0;
         foreach (jump[i]) jump[i] = '0;
         failures = 0;
      endfunction

      function void graft(logic [FIELD_W-1:0] child, logic [FIELD_W-1:0] parent);
         int lv;
         int j;
         if (child == 0) return;
         lv = depth_of[parent] + 1;
         if (lv > LEVEL_MAX) lv = LEVEL_MAX;
         depth_of[child] = lv[LEVEL_W-1:0];
         jump[child * LEVEL_COUNT] = parent;
         for (j = 1; j < LEVEL_COUNT; j++) begin
            jump[child * LEVEL_COUNT + j] =
               jump[jump[child * LEVEL_COUNT + j - 1] * LEVEL_COUNT + j - 1];
         end
      endfunction

      function logic [FIELD_W-1:0] lowest_common(logic [FIELD_W-1:0] u,
                                                 logic [FIELD_W-1:0] v);
         logic [FIELD_W-1:0] a;
         logic [FIELD_W-1:0] b;
         logic [LEVEL_W-1:0] gap;
         int j;
         if (u == v) return u;
         a = u;
         b = v;
         if (depth_of[u] < depth_of[v]) begin
            a = v;
            b = u;
         end
         gap = depth_of[a] - depth_of[b];
         for (j = LEVEL_COUNT - 1; j >= 0; j--) begin
            if (gap[j]) a = jump[a * LEVEL_COUNT + j];
         end
         if (a == b) return a;
         for (j = LEVEL_COUNT - 1; j >= 0; j--) begin
            if (jump[a * LEVEL_COUNT + j] != jump[b * LEVEL_COUNT + j]) begin
               a = jump[a * LEVEL_COUNT + j];
               b = jump[b * LEVEL_COUNT + j];
            end
         end
         return jump[a * LEVEL_COUNT];
      endfunction

      function void note_request(logic kind, logic [FIELD_W-1:0] first,
                                 logic [FIELD_W-1:0] second);
         if (kind == KIND_ATTACH) graft(first, second);
         else pending_ancestors.insert(pending_ancestors.size(),
                                       lowest_common(first, second));
      endfunction

      function void check_ancestor(logic [FIELD_W-1:0] actual);
         logic [FIELD_W-1:0] predicted;
         if (pending_ancestors.size() == 0) begin
            $error("unexpected response: ancestor actual %0d", actual);
            failures++;
            return;
         end
         predicted = pending_ancestors.pop_front();
         if (actual !== predicted) begin
            $error("ancestor: expected %0d, actual %0d", predicted, actual);
            failures++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic req_kind;
   logic [FIELD_W-1:0] req_first_node;
   logic [FIELD_W-1:0] req_second_node;
   logic rsp_valid;
   logic [FIELD_W-1:0] rsp_ancestor;

   ancestor_tracker tracker;
   bit placed [NODE_COUNT];
   int placed_list [$];
   int idle_pct;
   int cycle_count;

   lca_binary_lifting dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_kind(req_kind),
      .req_first_node(req_first_node),
      .req_second_node(req_second_node),
      .rsp_valid(rsp_valid),
      .rsp_ancestor(rsp_ancestor)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial cycle_count = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) tracker.check_ancestor(rsp_ancestor);
   end

   task automatic send_request(input logic kind, input int first, input int second);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_kind <= kind;
      req_first_node <= first[FIELD_W-1:0];
      req_second_node <= second[FIELD_W-1:0];
      do @(posedge clock); while (busy);
      tracker.note_request(kind, first[FIELD_W-1:0], second[FIELD_W-1:0]);
      if (kind == KIND_ATTACH && first != 0 && !placed[first]) begin
         placed[first] = 1'b1;
         placed_list.insert(placed_list.size(), first);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (tracker.pending_ancestors.size() != 0) @(posedge clock);
   endtask

   // bias toward recent nodes so the trees grow deep
   function automatic int pick_placed();
      int n;
      n = placed_list.size();
      if (n == 0) return 0;
      if ($urandom_range(99) < 55)
         return placed_list[n - 1 - $urandom_range(n < 8 ? n - 1 : 7)];
      return placed_list[$urandom_range(n - 1)];
   endfunction

   function automatic int pick_any();
      if ($urandom_range(99) < 4) return 0;
      return pick_placed();
   endfunction

   task automatic random_request();
      int child;
      int parent;
      int a;
      int b;
      if (placed_list.size() < 2 || $urandom_range(99) < 40) begin
         if (placed_list.size() >= NODE_COUNT - 1 || $urandom_range(99) < 12) begin
            child = placed_list[$urandom_range(placed_list.size() - 1)];
         end else begin
            do child = $urandom_range(NODE_COUNT - 1, 1); while (placed[child]);
         end
         if ($urandom_range(99) < 2) child = 0;
         parent = ($urandom_range(99) < 10) ? 0 : pick_placed();
         send_request(KIND_ATTACH, child, parent);
      end else begin
         a = pick_any();
         b = ($urandom_range(99) < 8) ? a : pick_any();
         send_request(KIND_QUERY, a, b);
      end
   endtask

   initial begin
      int idle_plan [4];
      int i;
      idle_plan = '{0, 69, 0, 32};
      tracker = new();
      idle_pct = 0;
      reset <= 1'b1;
      start <= 1'b0;
      req_kind <= KIND_ATTACH;
      req_first_node <= '0;
      req_second_node <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_request(KIND_ATTACH, 0, 0);
      send_request(KIND_ATTACH, 1023, 0);
      send_request(KIND_ATTACH, 512, 1023);
      send_request(KIND_ATTACH, 511, 1023);
      send_request(KIND_ATTACH, 1, 512);
      send_request(KIND_ATTACH, 2, 1);
      send_request(KIND_ATTACH, 3, 511);
      send_request(KIND_QUERY, 2, 3);
      send_request(KIND_QUERY, 3, 2);
      send_request(KIND_QUERY, 2, 2);
      send_request(KIND_QUERY, 1023, 2);
      send_request(KIND_QUERY, 2, 512);
      send_request(KIND_QUERY, 0, 2);
      send_request(KIND_QUERY, 0, 0);
      send_request(KIND_QUERY, 1023, 1023);
      send_request(KIND_ATTACH, 0, 1023);
      send_request(KIND_QUERY, 0, 1023);
      // reattach: descendants keep their old rows
      send_request(KIND_ATTACH, 512, 3);
      send_request(KIND_QUERY, 2, 512);
      send_request(KIND_QUERY, 1, 3);
      send_request(KIND_ATTACH, 3, 3);
      send_request(KIND_QUERY, 3, 511);
      drain();

      // ping-pong reattach builds deep levels
      send_request(KIND_ATTACH, 4, 0);
      for (i = 0; i < 20; i++) begin
         send_request(KIND_ATTACH, 5, 4);
         send_request(KIND_ATTACH, 4, 5);
      end
      send_request(KIND_ATTACH, 6, 4);
      send_request(KIND_QUERY, 6, 4);
      send_request(KIND_QUERY, 4, 5);
      send_request(KIND_QUERY, 6, 2);
      send_request(KIND_QUERY, 1023, 6);
      send_request(KIND_QUERY, 5, 0);
      drain();

      for (i = 0; i < 4; i++) begin
         idle_pct = idle_plan[i];
         repeat (320) random_request();
         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.failures == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule
